// ----- design/clle_pkg.sv -----
`default_nettype none
package clle_pkg;

  localparam int HeadW      = 4;
  localparam int ValW       = 32;
  localparam int MaxResults = 16;
  localparam int QDepth     = 2;
  localparam int TdataW     = 40;

  typedef enum logic [1:0] {
    KIND_FRONT = 2'd0,
    KIND_LAST  = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // hp already folds in the head-in-range check
  typedef struct packed {
    kind_e             kind;
    logic              hp;
    logic [HeadW-1:0]  head;
    logic [ValW-1:0]   value;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic [HeadW-1:0]  head;
    logic              hp;
    logic [ValW-1:0]   element;
    logic              last;
  } res_t;

endpackage
`default_nettype wire

// ----- design/clle_front.sv -----
`default_nettype none
module clle_front import clle_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       in_kind_i,
  input  logic [HeadW-1:0] in_head_i,
  input  logic             in_present_i,
  input  logic [ValW-1:0]  in_value_i,
  output logic             cmd_valid_o,
  input  logic             cmd_pop_i,
  output cmd_t             cmd_o
);

  localparam int PW = $clog2(QDepth);
  localparam int CW = $clog2(QDepth + 1);

  cmd_t          q_mem_q [QDepth];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          kind_ok;
  logic          push;
  cmd_t          cmd_w;

  always_comb begin
    unique case (in_kind_i) inside
      KIND_FRONT, KIND_LAST, KIND_READ: kind_ok = 1'b1;
      default:                          kind_ok = 1'b0;
    endcase
  end

  always_comb begin
    cmd_w.kind  = kind_e'(in_kind_i);
    cmd_w.hp    = in_present_i && (32'(in_head_i) < 32'(DEPTH));
    cmd_w.head  = in_head_i;
    cmd_w.value = in_value_i;
  end

  assign in_ready_o  = (cnt_q != CW'(QDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem_q[rd_ptr_q];

  // unused kind code is accepted and dropped here
  assign push = in_valid_i && in_ready_o && kind_ok;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (cmd_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CW'(push) - CW'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_w;
    end
  end

endmodule
`default_nettype wire

// ----- design/clle_back.sv -----
`default_nettype none
module clle_back import clle_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_pop_o,
  input  cmd_t cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_o
);

  localparam int IW   = $clog2(DEPTH);
  localparam int LW   = IW + 1;
  localparam int RLim = (DEPTH < MaxResults) ? DEPTH : MaxResults;
  localparam int KW   = $clog2(RLim);
  localparam logic [LW-1:0] NullLink = {1'b1, {IW{1'b0}}};

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ALLOC  = 5'b00010,
    S_TSTART = 5'b00100,
    S_TWALK  = 5'b01000,
    S_RWALK  = 5'b10000
  } state_e;

  state_e        state_q, state_d;
  cmd_t          cmd_q, cmd_d;
  logic [IW-1:0] hidx_q, hidx_d;
  logic [IW-1:0] node_q, node_d;
  logic [IW-1:0] cur_q, cur_d;
  logic [IW-1:0] hops_q, hops_d;
  logic [KW-1:0] k_q, k_d;
  logic [LW-1:0] free_q, free_d;

  // node store: value and link halves, each with per-entry written bits
  logic [ValW-1:0] val_mem [DEPTH];
  logic [LW-1:0]   lnk_mem [DEPTH];
  logic [DEPTH-1:0] val_vld_q, lnk_vld_q;

  logic            rd_en;
  logic [IW-1:0]   rd_addr;
  logic [IW-1:0]   rd_addr_q;
  logic [LW-1:0]   rd_lnk_q;
  logic [ValW-1:0] rd_val_q;
  logic            rd_lvld_q, rd_vvld_q;

  logic            lw_en, vw_en;
  logic [IW-1:0]   lw_addr, vw_addr;
  logic [LW-1:0]   lw_data;
  logic [ValW-1:0] vw_data;

  logic [LW-1:0]   lnk_eff;
  logic [ValW-1:0] val_eff;
  logic            lnk_null;
  logic [IW-1:0]   lnk_idx;
  logic            rd_stop;

  logic out_valid_q;
  res_t out_q;
  logic out_load;
  res_t out_d;
  logic out_free;

  // never-written entries read as their reset contents
  assign lnk_eff  = rd_lvld_q ? rd_lnk_q
                  : ((rd_addr_q == '0) ? NullLink : {1'b0, rd_addr_q - 1'b1});
  assign val_eff  = rd_vvld_q ? rd_val_q : '0;
  assign lnk_null = lnk_eff[IW];
  assign lnk_idx  = lnk_eff[IW-1:0];
  assign rd_stop  = lnk_null || (k_q == KW'(RLim - 1));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    hidx_d    = hidx_q;
    node_d    = node_q;
    cur_d     = cur_q;
    hops_d    = hops_q;
    k_d       = k_q;
    free_d    = free_q;
    cmd_pop_o = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = cur_q;
    lw_en     = 1'b0;
    lw_addr   = node_q;
    lw_data   = NullLink;
    vw_en     = 1'b0;
    vw_addr   = node_q;
    vw_data   = cmd_q.value;
    out_load  = 1'b0;
    out_d     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          hidx_d    = IW'(cmd_i.head);
          unique case (cmd_i.kind)
            KIND_FRONT, KIND_LAST: begin
              if (free_q[IW]) begin
                out_load     = 1'b1;
                out_d.status = ST_FULL;
                out_d.head   = cmd_i.hp ? cmd_i.head : '0;
                out_d.hp     = cmd_i.hp;
                out_d.last   = 1'b1;
              end else begin
                node_d  = free_q[IW-1:0];
                rd_en   = 1'b1;
                rd_addr = free_q[IW-1:0];
                state_d = S_ALLOC;
              end
            end
            KIND_READ: begin
              if (!cmd_i.hp) begin
                out_load     = 1'b1;
                out_d.status = ST_EMPTY;
                out_d.last   = 1'b1;
              end else begin
                rd_en   = 1'b1;
                rd_addr = IW'(cmd_i.head);
                k_d     = '0;
                state_d = S_RWALK;
              end
            end
            default: ;
          endcase
        end
      end

      S_ALLOC: begin
        // rd_lnk holds the taken node's link: it becomes the new free head
        if (out_free) begin
          free_d  = lnk_eff;
          vw_en   = 1'b1;
          lw_en   = 1'b1;
          if (cmd_q.kind == KIND_FRONT) begin
            lw_data      = cmd_q.hp ? {1'b0, hidx_q} : NullLink;
            out_load     = 1'b1;
            out_d.status = ST_OK;
            out_d.head   = HeadW'(node_q);
            out_d.hp     = 1'b1;
            out_d.last   = 1'b1;
            state_d      = S_IDLE;
          end else if (!cmd_q.hp) begin
            out_load     = 1'b1;
            out_d.status = ST_OK;
            out_d.head   = HeadW'(node_q);
            out_d.hp     = 1'b1;
            out_d.last   = 1'b1;
            state_d      = S_IDLE;
          end else begin
            state_d = S_TSTART;
          end
        end
      end

      S_TSTART: begin
        // the read is issued in the cycle after the new node's link write so the walk sees it
        rd_en   = 1'b1;
        rd_addr = hidx_q;
        cur_d   = hidx_q;
        hops_d  = '0;
        state_d = S_TWALK;
      end

      S_TWALK: begin
        if (!lnk_null && (hops_q != IW'(DEPTH - 1))) begin
          cur_d   = lnk_idx;
          hops_d  = hops_q + 1'b1;
          rd_en   = 1'b1;
          rd_addr = lnk_idx;
        end else if (out_free) begin
          lw_en        = 1'b1;
          lw_addr      = cur_q;
          lw_data      = {1'b0, node_q};
          out_load     = 1'b1;
          out_d.status = ST_OK;
          out_d.head   = cmd_q.head;
          out_d.hp     = 1'b1;
          out_d.last   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      S_RWALK: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_d.status  = ST_OK;
          out_d.head    = cmd_q.head;
          out_d.hp      = 1'b1;
          out_d.element = val_eff;
          out_d.last    = rd_stop;
          if (rd_stop) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            rd_en   = 1'b1;
            rd_addr = lnk_idx;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_q      <= {1'b0, IW'(DEPTH - 1)};
      val_vld_q   <= '0;
      lnk_vld_q   <= '0;
      rd_lvld_q   <= 1'b0;
      rd_vvld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      if (vw_en) begin
        val_vld_q[vw_addr] <= 1'b1;
      end
      if (lw_en) begin
        lnk_vld_q[lw_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_lvld_q <= lnk_vld_q[rd_addr];
        rd_vvld_q <= val_vld_q[rd_addr];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    hidx_q <= hidx_d;
    node_q <= node_d;
    cur_q  <= cur_d;
    hops_q <= hops_d;
    k_q    <= k_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lw_en) begin
      lnk_mem[lw_addr] <= lw_data;
    end
    if (vw_en) begin
      val_mem[vw_addr] <= vw_data;
    end
    if (rd_en) begin
      rd_addr_q <= rd_addr;
      rd_lnk_q  <= lnk_mem[rd_addr];
      rd_val_q  <= val_mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire

// ----- design/cursor_linked_list_engine_core.sv -----
// Linked lists of 32-bit values in a shared store of DEPTH nodes with a free
// list threaded through it; the caller keeps each list's head and passes it in
// with every transaction (tuser = kind: 0 insert front, 1 insert tail, 2 read;
// kind 3 is accepted and dropped). Inserts return one result with the new
// head; a read returns one result per element, the final one with tlast set.
// A two-entry command queue sits between the input and the list engine, and
// results leave through an output register, so the input keeps accepting,
// until the queue is full, while the engine walks or a result waits. Every
// node visit is one read of the single-port node store: insert-front reads
// the taken free node, insert-tail also walks the list from its head to the
// tail, and a read visits each element in turn (at most 16 elements).
// Status in tuser on results: 0 ok, 1 store full (insert dropped), 2 read of
// an empty list. No clearing pass is needed after reset.
`default_nettype none
module cursor_linked_list_engine_core import clle_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [3:0] head_index, [4] head_present, [36:5] value, [39:37] zero
  input  logic [TdataW-1:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]        s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [3:0] new_head_index, [4] new_head_present, [36:5] element, [39:37] zero
  output logic [TdataW-1:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]        m_axis_tuser,
  output logic              m_axis_tlast
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;
  res_t res;

  clle_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_kind_i    (s_axis_tuser),
    .in_head_i    (s_axis_tdata[HeadW-1:0]),
    .in_present_i (s_axis_tdata[HeadW]),
    .in_value_i   (s_axis_tdata[HeadW+ValW:HeadW+1]),
    .cmd_valid_o  (cmd_valid),
    .cmd_pop_i    (cmd_pop),
    .cmd_o        (cmd)
  );

  clle_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {{(TdataW - HeadW - 1 - ValW){1'b0}}, res.element, res.hp, res.head};
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;

endmodule
`default_nettype wire
